FILE: src/shb_pkg.sv
// Package: Streebog tables, round constants and the LPS transform function.
`timescale 1ns / 1ps
`default_nettype none
package shb_pkg;

    typedef logic [511:0] blk_t;

    typedef struct packed {
        blk_t       msg;
        logic       fin;
        logic [5:0] tail;
    } job_t;

    localparam int unsigned Rounds = 12;

    typedef logic [7:0] sbox_arr_t [256];
    localparam sbox_arr_t SBOX = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    typedef logic [63:0] lin_arr_t [64];
    localparam lin_arr_t LIN = '{
        64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
        64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
        64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
        64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
        64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
        64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
        64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
        64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
        64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
        64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
        64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
        64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
        64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
        64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
        64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
        64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
    };

    typedef blk_t rc_arr_t [12];
    localparam rc_arr_t RC = '{
        {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
         64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
        {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
         64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
        {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
         64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
        {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
         64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
        {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
         64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
        {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
         64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
        {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
         64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
        {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
         64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
        {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
         64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
        {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
         64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
        {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
         64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
        {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
         64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
    };

    // word 0 sits in bits 511:448
    function automatic blk_t lps(input blk_t w);
        blk_t       t;
        blk_t       o;
        logic [7:0] b;
        logic [63:0] c;
        for (int j = 0; j < 8; j++)
            for (int k = 0; k < 8; k++)
                t[511 - 64*j - 8*k -: 8] = SBOX[w[511 - 64*j - 8*k -: 8]];
        for (int i = 0; i < 8; i++)
        begin
            c = '0;
            for (int j = 0; j < 8; j++)
            begin
                b = t[511 - 64*j - 8*i -: 8];
                for (int k = 0; k < 8; k++)
                    if (b[7-k])
                        c = c ^ LIN[j*8 + k];
            end
            o[511 - 64*i -: 64] = c;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: src/streebog_hash_engine_unit.sv
// Streebog hash engine top level: front job queue and back compression engine.
// Flow: a pushed block is queued and taken when the back end is idle; a compression
// runs 1 key step, 24 half-round LPS steps and 1 update, and no new block is taken
// until it ends. A final block takes three compressions, then one digest word per pop.
// Throughput is set by the single shared LPS unit: one LPS per cycle, two per round.
// Reset: asynchronous active low; 512-bit mode, zero IV, counter and checksum cleared.
`timescale 1ns / 1ps
`default_nettype none
module streebog_hash_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] msg_word_0,
    input  wire logic [63:0] msg_word_1,
    input  wire logic [63:0] msg_word_2,
    input  wire logic [63:0] msg_word_3,
    input  wire logic [63:0] msg_word_4,
    input  wire logic [63:0] msg_word_5,
    input  wire logic [63:0] msg_word_6,
    input  wire logic [63:0] msg_word_7,
    input  wire logic        final_block,
    input  wire logic [5:0]  tail_bytes,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      hash_word,
    output logic             last_word
);
    shb_pkg::job_t job_in, job_q;
    logic          job_valid, job_take;

    assign job_in.msg  = {msg_word_0, msg_word_1, msg_word_2, msg_word_3,
                          msg_word_4, msg_word_5, msg_word_6, msg_word_7};
    assign job_in.fin  = final_block;
    assign job_in.tail = tail_bytes;

    shb_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .job_in(job_in),
        .job_valid(job_valid), .job_take(job_take), .job_out(job_q)
    );

    shb_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_size(cfg_data),
        .job_valid(job_valid), .job_take(job_take), .job(job_q),
        .empty(empty), .pop(pop), .hash_word(hash_word), .last_word(last_word)
    );
endmodule
`default_nettype wire

FILE: src/shb_front.sv
// Front end: input transaction capture into a two-entry job queue.
`timescale 1ns / 1ps
`default_nettype none
module shb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire shb_pkg::job_t job_in,
    output logic               job_valid,
    input  wire logic          job_take,
    output shb_pkg::job_t      job_out
);
    shb_pkg::job_t q_reg [2];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = cnt_reg[1];
    assign job_valid = (cnt_reg != 2'd0);
    assign job_out   = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= job_in;
    end

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("job queue count overflow");
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> full)
        else $error("queue left full state without a pop");
    a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("pop did not decrement count");
`endif
endmodule
`default_nettype wire

FILE: src/shb_back.sv
// Back end: compression sequencer with shared LPS unit, counters and digest output.
`timescale 1ns / 1ps
`default_nettype none
module shb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_size,
    input  wire logic          job_valid,
    output logic               job_take,
    input  wire shb_pkg::job_t job,
    output logic               empty,
    input  wire logic          pop,
    output logic [63:0]        hash_word,
    output logic               last_word
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KEY  = 5'b00010,
        S_RND  = 5'b00100,
        S_END  = 5'b01000,
        S_OUT  = 5'b10000
    } st_t;

    st_t               st_reg, st_next;
    shb_pkg::blk_t     h_reg, n_reg, s_reg, k_reg, e_reg, m_reg;
    logic              size_reg;
    logic [4:0]        r_reg;
    logic [1:0]        ph_reg;
    logic              fin_reg;
    logic [5:0]        tail_reg;
    logic [2:0]        oi_reg;
    logic              ov_reg;
    logic              last_half;
    shb_pkg::blk_t     lps_in, lps_out, pad_m, iv, n_inc, rc;
    logic [5:0]        tl;

    assign iv = size_reg ? '0 : {64{8'h01}};
    assign tl = job.tail;

    always_comb
    begin
        for (int p = 0; p < 64; p++)
        begin
            if (p >= 64 - int'(tl))
                pad_m[511 - 8*p -: 8] = job.msg[511 - 8*p -: 8];
            else if (p == 63 - int'(tl))
                pad_m[511 - 8*p -: 8] = 8'h01;
            else
                pad_m[511 - 8*p -: 8] = 8'h00;
        end
    end

    assign last_half = (r_reg == 5'(2*shb_pkg::Rounds - 1));
    assign rc        = shb_pkg::RC[r_reg[4:1]];
    assign lps_in    = (st_reg == S_KEY) ? (h_reg ^ (ph_reg == 2'd0 ? n_reg : '0))
                     : (r_reg[0] ? (k_reg ^ rc) : e_reg);
    assign lps_out   = shb_pkg::lps(lps_in);
    assign n_inc     = fin_reg ? {503'd0, tail_reg, 3'd0} : 512'd512;

    assign job_take  = (st_reg == S_IDLE) && job_valid && !cfg_we;
    assign empty     = !ov_reg;
    assign hash_word = h_reg[511 - 64*oi_reg -: 64];
    assign last_word = size_reg ? (oi_reg == 3'd7) : (oi_reg == 3'd3);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (job_take) st_next = S_KEY;
            S_KEY:  st_next = S_RND;
            S_RND:  if (last_half) st_next = S_END;
            S_END:  st_next = (ph_reg == 2'd0 && !fin_reg) ? S_IDLE
                            : (ph_reg == 2'd2) ? S_OUT : S_KEY;
            S_OUT:  if (pop && ov_reg && last_word) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // r_reg counts half-rounds: even = state LPS, odd = key LPS
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            size_reg <= 1'b1;
            r_reg    <= 5'd0;
            ph_reg   <= 2'd0;
            fin_reg  <= 1'b0;
            tail_reg <= 6'd0;
            oi_reg   <= 3'd0;
            ov_reg   <= 1'b0;
            h_reg    <= '0;
            n_reg    <= '0;
            s_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                size_reg <= cfg_size;
                h_reg    <= cfg_size ? '0 : {64{8'h01}};
                n_reg    <= '0;
                s_reg    <= '0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        fin_reg  <= job.fin;
                        tail_reg <= job.tail;
                        ph_reg   <= 2'd0;
                        m_reg    <= job.fin ? pad_m : job.msg;
                    end
                end
                S_KEY:
                begin
                    k_reg <= lps_out;
                    e_reg <= lps_out ^ m_reg;
                    r_reg <= 5'd0;
                end
                S_RND:
                begin
                    if (!r_reg[0])
                        e_reg <= lps_out;
                    else
                    begin
                        k_reg <= lps_out;
                        e_reg <= e_reg ^ lps_out;
                    end
                    r_reg <= last_half ? 5'd0 : r_reg + 5'd1;
                end
                S_END:
                begin
                    h_reg <= h_reg ^ e_reg ^ m_reg;
                    if (ph_reg == 2'd0)
                    begin
                        n_reg  <= n_reg + n_inc;
                        s_reg  <= s_reg + m_reg;
                        m_reg  <= n_reg + n_inc;
                        ph_reg <= 2'd1;
                    end
                    else if (ph_reg == 2'd1)
                    begin
                        m_reg  <= s_reg;
                        ph_reg <= 2'd2;
                    end
                    oi_reg <= 3'd0;
                    ov_reg <= (ph_reg == 2'd2);
                end
                S_OUT:
                begin
                    if (pop && ov_reg)
                    begin
                        oi_reg <= oi_reg + 3'd1;
                        if (last_word)
                        begin
                            ov_reg <= 1'b0;
                            h_reg  <= iv;
                            n_reg  <= '0;
                            s_reg  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> st_reg == S_IDLE)
        else $error("job taken while busy");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> st_reg == S_OUT)
        else $error("result shown outside output state");
    a_rnd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_RND |-> r_reg < 5'd24)
        else $error("half-round counter past twenty-four");
`endif
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the Streebog hash engine: queued driver, digest predictor and word checker.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    typedef struct {
        shb_pkg::blk_t msg;
        logic          fin;
        logic [5:0]    tail;
    } block_item_t;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        push;
    logic        full;
    logic [63:0] msg_word_0, msg_word_1, msg_word_2, msg_word_3;
    logic [63:0] msg_word_4, msg_word_5, msg_word_6, msg_word_7;
    logic        final_block;
    logic [5:0]  tail_bytes;
    logic        empty;
    logic        pop;
    logic [63:0] hash_word;
    logic        last_word;

    block_item_t  pending_blocks[$];
    digest_word_t expected_words[$];
    int           error_count;
    int           digests_seen;
    int           words_checked;
    int           blocks_sent;
    logic         feed_enable;
    int           burst_left;
    int           gap_left;
    int           pop_phase;

    logic          mode_512;
    shb_pkg::blk_t chain_h;
    shb_pkg::blk_t count_n;
    shb_pkg::blk_t sum_s;

    streebog_hash_engine_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .push(push), .full(full),
        .msg_word_0(msg_word_0), .msg_word_1(msg_word_1), .msg_word_2(msg_word_2),
        .msg_word_3(msg_word_3), .msg_word_4(msg_word_4), .msg_word_5(msg_word_5),
        .msg_word_6(msg_word_6), .msg_word_7(msg_word_7),
        .final_block(final_block), .tail_bytes(tail_bytes),
        .empty(empty), .pop(pop), .hash_word(hash_word), .last_word(last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic shb_pkg::blk_t substitute_permute_mix(input shb_pkg::blk_t w);
        shb_pkg::blk_t t;
        shb_pkg::blk_t o;
        logic [7:0]    b;
        logic [63:0]   acc;
        for (int j = 0; j < 64; j++)
            t[511 - 8*j -: 8] = shb_pkg::SBOX[w[511 - 8*j -: 8]];
        for (int i = 0; i < 8; i++)
        begin
            acc = '0;
            for (int j = 0; j < 8; j++)
            begin
                b = t[511 - 64*j - 8*i -: 8];
                for (int k = 0; k < 8; k++)
                    if (b[7-k])
                        acc ^= shb_pkg::LIN[j*8 + k];
            end
            o[511 - 64*i -: 64] = acc;
        end
        return o;
    endfunction

    function automatic shb_pkg::blk_t compress_block(input shb_pkg::blk_t h,
                                                     input shb_pkg::blk_t n,
                                                     input shb_pkg::blk_t m);
        shb_pkg::blk_t key;
        shb_pkg::blk_t st;
        key = substitute_permute_mix(h ^ n);
        st = key ^ m;
        for (int r = 0; r < 12; r++)
        begin
            st = substitute_permute_mix(st);
            key = substitute_permute_mix(key ^ shb_pkg::RC[r]);
            st ^= key;
        end
        return h ^ st ^ m;
    endfunction

    function automatic void restart_chain();
        chain_h = mode_512 ? '0 : {64{8'h01}};
        count_n = '0;
        sum_s = '0;
    endfunction

    function automatic void predict_digest(input block_item_t it);
        shb_pkg::blk_t m;
        int            words;
        if (!it.fin)
        begin
            chain_h = compress_block(chain_h, count_n, it.msg);
            count_n = count_n + 512'd512;
            sum_s = sum_s + it.msg;
            return;
        end
        m = '0;
        for (int p = 0; p < 64; p++)
            if (p >= 64 - int'(it.tail))
                m[511 - 8*p -: 8] = it.msg[511 - 8*p -: 8];
            else if (p == 63 - int'(it.tail))
                m[511 - 8*p -: 8] = 8'h01;
        chain_h = compress_block(chain_h, count_n, m);
        count_n = count_n + {503'd0, it.tail, 3'd0};
        sum_s = sum_s + m;
        chain_h = compress_block(chain_h, '0, count_n);
        chain_h = compress_block(chain_h, '0, sum_s);
        words = mode_512 ? 8 : 4;
        for (int i = 0; i < words; i++)
            expected_words.push_back('{chain_h[511 - 64*i -: 64], i == words - 1});
        restart_chain();
    endfunction

    function automatic shb_pkg::blk_t random_block();
        shb_pkg::blk_t b;
        for (int i = 0; i < 16; i++)
            b[32*i +: 32] = $urandom;
        return b;
    endfunction

    task automatic queue_block(input shb_pkg::blk_t msg, input logic fin,
                               input logic [5:0] tail);
        pending_blocks.push_back('{msg, fin, tail});
    endtask

    task automatic drain_and_wait();
        while (pending_blocks.size() != 0 || push || expected_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_512 = m;
        restart_chain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_digest('{{msg_word_0, msg_word_1, msg_word_2, msg_word_3,
                                  msg_word_4, msg_word_5, msg_word_6, msg_word_7},
                                 final_block, tail_bytes});
                blocks_sent++;
            end
            if (push && full)
            begin
                // hold current transaction
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (feed_enable && pending_blocks.size() != 0)
            begin
                block_item_t it;
                it = pending_blocks.pop_front();
                {msg_word_0, msg_word_1, msg_word_2, msg_word_3,
                 msg_word_4, msg_word_5, msg_word_6, msg_word_7} <= it.msg;
                final_block <= it.fin;
                tail_bytes <= it.tail;
                push <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                digest_word_t exp;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected digest word %h", hash_word);
                    error_count++;
                end
                else
                begin
                    exp = expected_words.pop_front();
                    words_checked++;
                    if (hash_word !== exp.word)
                    begin
                        $error("hash_word expected %h actual %h", exp.word, hash_word);
                        error_count++;
                    end
                    if (last_word !== exp.last)
                    begin
                        $error("last_word expected %b actual %b", exp.last, last_word);
                        error_count++;
                    end
                    if (exp.last)
                        digests_seen++;
                end
            end
            pop_phase = (pop_phase + 1) % 23;
            pop <= (pop_phase < 8) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int n;
        shb_pkg::blk_t b;
        error_count = 0;
        digests_seen = 0;
        words_checked = 0;
        blocks_sent = 0;
        feed_enable = 1'b1;
        burst_left = 0;
        gap_left = 0;
        pop_phase = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        {msg_word_0, msg_word_1, msg_word_2, msg_word_3} = '0;
        {msg_word_4, msg_word_5, msg_word_6, msg_word_7} = '0;
        final_block = 1'b0;
        tail_bytes = '0;
        mode_512 = 1'b1;
        restart_chain();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_block('0, 1'b1, 6'd0);
        queue_block('1, 1'b1, 6'd63);
        queue_block('1, 1'b0, 6'd0);
        queue_block(random_block(), 1'b1, 6'd1);
        queue_block('0, 1'b0, 6'd63);
        queue_block('1, 1'b0, 6'd17);
        queue_block(random_block(), 1'b1, 6'd32);
        drain_and_wait();

        write_mode(1'b0);
        queue_block('1, 1'b1, 6'd63);
        queue_block(random_block(), 1'b0, 6'd0);
        queue_block('1, 1'b1, 6'd0);
        drain_and_wait();

        write_mode(1'b1);
        queue_block(random_block(), 1'b0, 6'd5);
        drain_and_wait();
        write_mode(1'b0);
        queue_block(random_block(), 1'b1, 6'd40);
        drain_and_wait();

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
                write_mode(phase[0] ? 1'b1 : 1'b0);
            for (int k = 0; k < 35; k++)
            begin
                n = $urandom_range(0, 5);
                b = random_block();
                queue_block(b, ($urandom_range(0, 3) == 0) ? 1'b1 : (n == 0),
                            6'($urandom_range(0, 63)));
            end
            queue_block(random_block(), 1'b1, 6'($urandom_range(0, 63)));
            if (phase == 1)
            begin
                while (pending_blocks.size() > 15)
                    @(posedge clk);
                feed_enable = 1'b0;
                while (push || expected_words.size() != 0)
                    @(posedge clk);
                feed_enable = 1'b1;
            end
            drain_and_wait();
        end

        $display("Sent %0d blocks in both digest sizes; checked %0d words of %0d digests",
                 blocks_sent, words_checked, digests_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
